FILE: sv/stb_pkg.sv
// stb_pkg: shared constants for the soft timer bank.
// Holds the opcode codes, the fixed field widths and the parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

	// Fixed field widths of the item and result ports
	localparam int OPCODE_W = 3;
	localparam int INDEX_W  = 5;
	localparam int WORD_W   = 32;

	// Parameter defaults
	localparam int NUM_TIMERS_DEF = 16;
	localparam int TICK_WIDTH_DEF = 32;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_SCAN    = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_ALLOC   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_RELEASE = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SET_PER = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_RESTART = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_MK_RDY  = 3'd6;

	// Status codes
	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_ERR = 1'b1;

endpackage

`default_nettype wire

FILE: sv/soft_timer_bank.sv
// soft_timer_bank: pool of periodic timers sharing one tick counter, advanced by tick items.
// Periods and last-run stamps live in two single-port-write synchronous memories.
// Depends on stb_pkg.
//
// Usage: an item (opcode, timer_index, period_ticks) is taken at a rising edge
// with start high and busy low. Each item gives one result, shown for exactly
// one cycle with done high; the receiver cannot stall it.
// Behaviour by opcode:
//   tick, allocate, release, set period, restart, unused opcode: result in the
//     cycle after accept, busy stays low, one item per cycle.
//   make ready: one memory read of the period, then the write in ST_MK_RDY;
//     busy for one cycle, result registered in ST_MK_RDY.
//   scan: each timer entry passes a three-stage read / elapsed / compare-and-
//     write-back pipeline, one entry per cycle; busy through ST_SCAN and
//     ST_FINISH, result registered in ST_FINISH.
// Reset clears the tick counter, the allocation map and the per-entry valid
// bits; an entry never written since reset reads as zero, so no clearing pass
// is needed and the block takes items right after reset.
`timescale 1ns / 1ps
`default_nettype none

module soft_timer_bank #(
	parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
	parameter int TICK_WIDTH = stb_pkg::TICK_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [stb_pkg::OPCODE_W-1:0]   opcode,
	input  wire logic [stb_pkg::INDEX_W-1:0]    timer_index,
	input  wire logic [stb_pkg::WORD_W-1:0]     period_ticks,
	output logic                                done,
	output logic                                status,
	output logic [stb_pkg::INDEX_W-1:0]         granted_index,
	output logic [stb_pkg::WORD_W-1:0]          fired_mask,
	output logic [stb_pkg::WORD_W-1:0]          least_remaining,
	output logic [stb_pkg::INDEX_W-1:0]         soonest_index
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_TIMERS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);
	localparam logic [stb_pkg::INDEX_W:0] IDX_LIM = (stb_pkg::INDEX_W + 1)'(NUM_TIMERS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_FINISH = 4'b0100,
		ST_MK_RDY = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [TICK_WIDTH-1:0]   now_q;
	logic [NUM_TIMERS-1:0]   in_use_q;
	logic [NUM_TIMERS-1:0]   per_vld_q;
	logic [NUM_TIMERS-1:0]   lr_vld_q;
	logic [IDX_W-1:0]        idx_q;

	// Scan sweep and accumulators
	logic [CNT_W-1:0]        cnt_q;
	logic                    any_q;
	logic [TICK_WIDTH-1:0]   least_q;
	logic [IDX_W-1:0]        soonest_q;
	logic [NUM_TIMERS-1:0]   fired_q;

	// Result registers
	logic                    done_q;
	logic                    status_q;
	logic [stb_pkg::INDEX_W-1:0] granted_q;
	logic [stb_pkg::WORD_W-1:0]  fired_out_q;
	logic [stb_pkg::WORD_W-1:0]  least_out_q;
	logic [stb_pkg::INDEX_W-1:0] soonest_out_q;

	// Memories
	logic [TICK_WIDTH-1:0]   per_mem [NUM_TIMERS];
	logic [TICK_WIDTH-1:0]   lr_mem  [NUM_TIMERS];

	// Pipeline
	logic [TICK_WIDTH-1:0]   per_raw_s1;
	logic [TICK_WIDTH-1:0]   lr_raw_s1;
	logic                    per_v_s1;
	logic                    lr_v_s1;
	logic                    vld_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [TICK_WIDTH-1:0]   elapsed_s2;
	logic [TICK_WIDTH-1:0]   period_s2;
	logic                    vld_s2;
	logic [IDX_W-1:0]        idx_s2;

	logic                    accept;
	logic                    idx_ok;
	logic [IDX_W-1:0]        addr_in;
	logic [TICK_WIDTH-1:0]   per_in;
	logic [TICK_WIDTH-1:0]   per_rd;
	logic [TICK_WIDTH-1:0]   lr_rd;
	logic [IDX_W-1:0]        rd_addr;
	logic                    issue;
	logic                    free_found;
	logic [IDX_W-1:0]        free_idx;

	logic                    per_we;
	logic [IDX_W-1:0]        per_wa;
	logic [TICK_WIDTH-1:0]   per_wd;
	logic                    lr_we;
	logic [IDX_W-1:0]        lr_wa;
	logic [TICK_WIDTH-1:0]   lr_wd;

	logic                    active3;
	logic                    expired3;
	logic                    fire3;
	logic [TICK_WIDTH-1:0]   rem3;
	logic                    take3;

	// Handshake and decoded item fields
	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign idx_ok  = ({1'b0, timer_index} < IDX_LIM);
	assign addr_in = timer_index[IDX_W-1:0];
	assign per_in  = period_ticks[TICK_WIDTH-1:0];
	assign issue   = (cnt_q < CNT_END);
	assign rd_addr = (state_q == ST_SCAN) ? cnt_q[IDX_W-1:0] : addr_in;

	// Entries never written since reset read as zero
	assign per_rd = per_v_s1 ? per_raw_s1 : '0;
	assign lr_rd  = lr_v_s1 ? lr_raw_s1 : '0;

	// Lowest free timer
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// Scan stage 3: expiry, post-fire remaining time, running minimum
	assign active3  = vld_s2 && in_use_q[idx_s2];
	assign expired3 = (elapsed_s2 >= period_s2);
	assign fire3    = active3 && expired3;
	// a fired timer restarts from now, so its remaining time is its period
	assign rem3     = expired3 ? period_s2 : (period_s2 - elapsed_s2);
	assign take3    = active3 && (!any_q || (rem3 < least_q));

	// Memory write port selection
	always_comb begin
		per_we = 1'b0;
		per_wa = addr_in;
		per_wd = per_in;
		lr_we  = 1'b0;
		lr_wa  = addr_in;
		lr_wd  = now_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && idx_ok) begin
					case (opcode)
						stb_pkg::OP_RELEASE: begin
							if (in_use_q[addr_in]) begin
								per_we = 1'b1;
								per_wd = '0;
								lr_we  = 1'b1;
								lr_wd  = '0;
							end
						end
						stb_pkg::OP_SET_PER: per_we = 1'b1;
						stb_pkg::OP_RESTART: lr_we = 1'b1;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				lr_we = fire3;
				lr_wa = idx_s2;
			end
			ST_MK_RDY: begin
				lr_we = 1'b1;
				lr_wa = idx_q;
				lr_wd = now_q - per_rd - TICK_WIDTH'(1);
			end
			default: ;
		endcase
	end

	// Memories and read data registers
	always_ff @(posedge clk) begin
		if (per_we) begin
			per_mem[per_wa] <= per_wd;
		end
		if (lr_we) begin
			lr_mem[lr_wa] <= lr_wd;
		end
		per_raw_s1 <= per_mem[rd_addr];
		lr_raw_s1  <= lr_mem[rd_addr];
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		idx_s1     <= rd_addr;
		elapsed_s2 <= now_q - lr_rd;
		period_s2  <= per_rd;
		idx_s2     <= idx_s1;
	end

	// Valid bits of the memory entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_vld_q <= '0;
			lr_vld_q  <= '0;
			per_v_s1  <= 1'b0;
			lr_v_s1   <= 1'b0;
		end else begin
			if (per_we) begin
				per_vld_q[per_wa] <= 1'b1;
			end
			if (lr_we) begin
				lr_vld_q[lr_wa] <= 1'b1;
			end
			per_v_s1 <= per_vld_q[rd_addr];
			lr_v_s1  <= lr_vld_q[rd_addr];
		end
	end

	// Control, counters and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			now_q         <= '0;
			in_use_q      <= '0;
			idx_q         <= '0;
			cnt_q         <= '0;
			any_q         <= 1'b0;
			least_q       <= '0;
			soonest_q     <= '0;
			fired_q       <= '0;
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			done_q        <= 1'b0;
			status_q      <= stb_pkg::STAT_OK;
			granted_q     <= '0;
			fired_out_q   <= '0;
			least_out_q   <= '0;
			soonest_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == ST_SCAN) && issue;
			vld_s2 <= vld_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q      <= stb_pkg::STAT_OK;
						granted_q     <= '0;
						fired_out_q   <= '0;
						least_out_q   <= '0;
						soonest_out_q <= '0;
						done_q        <= 1'b1;
						case (opcode)
							stb_pkg::OP_TICK: now_q <= now_q + TICK_WIDTH'(1);
							stb_pkg::OP_SCAN: begin
								done_q    <= 1'b0;
								state_q   <= ST_SCAN;
								cnt_q     <= '0;
								any_q     <= 1'b0;
								least_q   <= '1;
								soonest_q <= '0;
								fired_q   <= '0;
							end
							stb_pkg::OP_ALLOC: begin
								if (free_found) begin
									in_use_q[free_idx] <= 1'b1;
									granted_q <= stb_pkg::INDEX_W'(free_idx);
								end else begin
									status_q <= stb_pkg::STAT_ERR;
								end
							end
							stb_pkg::OP_RELEASE: begin
								if (idx_ok && in_use_q[addr_in]) begin
									in_use_q[addr_in] <= 1'b0;
								end else begin
									status_q <= stb_pkg::STAT_ERR;
								end
							end
							stb_pkg::OP_SET_PER,
							stb_pkg::OP_RESTART: begin
								if (!idx_ok) begin
									status_q <= stb_pkg::STAT_ERR;
								end
							end
							stb_pkg::OP_MK_RDY: begin
								if (idx_ok) begin
									done_q  <= 1'b0;
									state_q <= ST_MK_RDY;
									idx_q   <= addr_in;
								end else begin
									status_q <= stb_pkg::STAT_ERR;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (fire3) begin
						fired_q[idx_s2] <= 1'b1;
					end
					if (take3) begin
						any_q     <= 1'b1;
						least_q   <= rem3;
						soonest_q <= idx_s2;
					end
					if (vld_s2 && (idx_s2 == IDX_LAST)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q        <= 1'b1;
					fired_out_q   <= stb_pkg::WORD_W'(fired_q);
					least_out_q   <= stb_pkg::WORD_W'(least_q);
					soonest_out_q <= stb_pkg::INDEX_W'(soonest_q);
					state_q       <= ST_IDLE;
				end
				ST_MK_RDY: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign granted_index   = granted_q;
	assign fired_mask      = fired_out_q;
	assign least_remaining = least_out_q;
	assign soonest_index   = soonest_out_q;

	// Checks
	a_quick_ops_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode != stb_pkg::OP_SCAN) && (opcode != stb_pkg::OP_MK_RDY)) |=> done)
		else $error("single-cycle item gave no result");

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (state_q == ST_SCAN))
		else $error("scan pipeline active outside a scan");

	a_fired_are_active: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((fired_mask & ~stb_pkg::WORD_W'(in_use_q)) == '0))
		else $error("free timer reported as fired");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == stb_pkg::STAT_ERR)) |-> ((fired_mask == '0) && (least_remaining == '0)))
		else $error("error result carries scan data");

endmodule

`default_nettype wire

FILE: verif/soft_timer_bank_tb.sv
// soft_timer_bank_tb: self-checking bench for the periodic timer pool.
// A clocked driver feeds commands from a queue, and a clocked monitor checks each result
// against a cycle-free copy of the pool. Depends on stb_pkg and soft_timer_bank.
`timescale 1ns / 1ps

module soft_timer_bank_tb;

	localparam int NT = stb_pkg::NUM_TIMERS_DEF;
	localparam int TW = stb_pkg::TICK_WIDTH_DEF;
	localparam logic [stb_pkg::WORD_W-1:0] TICK_MASK = 32'hFFFF_FFFF >> (32 - TW);
	// opcode with no function in the block
	localparam logic [stb_pkg::OPCODE_W-1:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic [stb_pkg::OPCODE_W-1:0] op;
		logic [stb_pkg::INDEX_W-1:0]  idx;
		logic [stb_pkg::WORD_W-1:0]   per;
	} timer_cmd_t;

	typedef struct packed {
		logic                         status;
		logic [stb_pkg::INDEX_W-1:0]  granted;
		logic [stb_pkg::WORD_W-1:0]   fired;
		logic [stb_pkg::WORD_W-1:0]   least;
		logic [stb_pkg::INDEX_W-1:0]  soonest;
	} timer_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [stb_pkg::OPCODE_W-1:0] opcode = stb_pkg::OP_TICK;
	logic [stb_pkg::INDEX_W-1:0] timer_index = '0;
	logic [stb_pkg::WORD_W-1:0] period_ticks = '0;
	logic busy, done, status;
	logic [stb_pkg::INDEX_W-1:0] granted_index, soonest_index;
	logic [stb_pkg::WORD_W-1:0] fired_mask, least_remaining;

	soft_timer_bank #(
		.NUM_TIMERS(NT),
		.TICK_WIDTH(TW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.timer_index(timer_index),
		.period_ticks(period_ticks),
		.done(done),
		.status(status),
		.granted_index(granted_index),
		.fired_mask(fired_mask),
		.least_remaining(least_remaining),
		.soonest_index(soonest_index)
	);

	always #4 clk = ~clk;

	// shadow copy of the pool
	logic [stb_pkg::WORD_W-1:0] now_ticks = '0;
	logic [NT-1:0] taken_map = '0;
	logic [stb_pkg::WORD_W-1:0] period_mem [NT];
	logic [stb_pkg::WORD_W-1:0] last_run_mem [NT];

	timer_cmd_t cmd_queue[$];
	timer_res_t timer_answers[$];
	timer_cmd_t cur_cmd;
	int idle_pct = 13;
	int errors = 0;

	initial begin
		for (int t = 0; t < NT; t++) begin
			period_mem[t] = '0;
			last_run_mem[t] = '0;
		end
	end

	function automatic logic [stb_pkg::WORD_W-1:0] ticks_left(int t);
		logic [stb_pkg::WORD_W-1:0] elapsed;
		elapsed = (now_ticks - last_run_mem[t]) & TICK_MASK;
		if (elapsed >= period_mem[t])
			return '0;
		return period_mem[t] - elapsed;
	endfunction

	// apply one command to the shadow pool and return the result it gives
	function automatic timer_res_t pool_apply(timer_cmd_t c);
		timer_res_t r;
		logic idx_ok;
		logic found;
		logic [stb_pkg::WORD_W-1:0] left;
		r = '0;
		idx_ok = c.idx < NT;
		found = 1'b0;
		case (c.op)
			stb_pkg::OP_TICK: begin
				now_ticks = (now_ticks + 1) & TICK_MASK;
			end
			stb_pkg::OP_SCAN: begin
				// fire pass first, then the least-remaining pass over allocated entries
				for (int t = 0; t < NT; t++) begin
					if (taken_map[t] && ticks_left(t) == 0) begin
						last_run_mem[t] = now_ticks;
						r.fired[t] = 1'b1;
					end
				end
				r.least = TICK_MASK;
				for (int t = 0; t < NT; t++) begin
					if (taken_map[t]) begin
						left = ticks_left(t);
						if (!found || left < r.least) begin
							r.least = left;
							r.soonest = stb_pkg::INDEX_W'(t);
							found = 1'b1;
						end
					end
				end
			end
			stb_pkg::OP_ALLOC: begin
				r.status = stb_pkg::STAT_ERR;
				for (int t = 0; t < NT; t++) begin
					if (!found && !taken_map[t]) begin
						taken_map[t] = 1'b1;
						r.granted = stb_pkg::INDEX_W'(t);
						r.status = stb_pkg::STAT_OK;
						found = 1'b1;
					end
				end
			end
			stb_pkg::OP_RELEASE: begin
				if (!idx_ok || !taken_map[c.idx]) begin
					r.status = stb_pkg::STAT_ERR;
				end else begin
					taken_map[c.idx] = 1'b0;
					period_mem[c.idx] = '0;
					last_run_mem[c.idx] = '0;
				end
			end
			stb_pkg::OP_SET_PER: begin
				if (!idx_ok) r.status = stb_pkg::STAT_ERR;
				else period_mem[c.idx] = c.per & TICK_MASK;
			end
			stb_pkg::OP_RESTART: begin
				if (!idx_ok) r.status = stb_pkg::STAT_ERR;
				else last_run_mem[c.idx] = now_ticks;
			end
			stb_pkg::OP_MK_RDY: begin
				if (!idx_ok) r.status = stb_pkg::STAT_ERR;
				else last_run_mem[c.idx] = (now_ticks - period_mem[c.idx] - 1) & TICK_MASK;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// driver: hold the item until taken, then load the next one or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				timer_answers.push_back(pool_apply(cur_cmd));
			if (!start || !busy) begin
				if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cur_cmd = cmd_queue.pop_front();
					start <= 1'b1;
					opcode <= cur_cmd.op;
					timer_index <= cur_cmd.idx;
					period_ticks <= cur_cmd.per;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic field_check(string name, logic [stb_pkg::WORD_W-1:0] want,
			logic [stb_pkg::WORD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// monitor: every strobed result against the oldest prediction
	always @(posedge clk) begin
		timer_res_t want;
		if (arst_n && done) begin
			if (timer_answers.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %b fired %h",
					$time, status, fired_mask);
				errors++;
			end else begin
				want = timer_answers.pop_front();
				field_check("status", want.status, status);
				field_check("granted_index", want.granted, granted_index);
				field_check("fired_mask", want.fired, fired_mask);
				field_check("least_remaining", want.least, least_remaining);
				field_check("soonest_index", want.soonest, soonest_index);
			end
		end
	end

	task automatic push_cmd(logic [stb_pkg::OPCODE_W-1:0] op, logic [stb_pkg::INDEX_W-1:0] idx,
			logic [stb_pkg::WORD_W-1:0] per);
		timer_cmd_t c;
		c.op = op;
		c.idx = idx;
		c.per = per;
		cmd_queue.push_back(c);
	endtask

	function automatic logic [stb_pkg::WORD_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(0, 12);
		if (r < 85) return $urandom_range(0, 300);
		return $urandom;
	endfunction

	function automatic logic [stb_pkg::INDEX_W-1:0] pick_index();
		if ($urandom_range(0, 99) < 85) return stb_pkg::INDEX_W'($urandom_range(0, NT - 1));
		return stb_pkg::INDEX_W'($urandom_range(NT, 31));
	endfunction

	function automatic logic [stb_pkg::OPCODE_W-1:0] pick_opcode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 33) return stb_pkg::OP_TICK;
		if (r < 53) return stb_pkg::OP_SCAN;
		if (r < 63) return stb_pkg::OP_ALLOC;
		if (r < 72) return stb_pkg::OP_RELEASE;
		if (r < 84) return stb_pkg::OP_SET_PER;
		if (r < 90) return stb_pkg::OP_RESTART;
		if (r < 97) return stb_pkg::OP_MK_RDY;
		return OP_UNUSED;
	endfunction

	// random commands: tick runs ending in a scan, pool fills, timer setups, mostly single commands
	task automatic fill_random(int n);
		int count;
		int r;
		int k;
		logic [stb_pkg::INDEX_W-1:0] idx;
		count = 0;
		while (count < n) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				k = $urandom_range(1, 12);
				repeat (k) push_cmd(stb_pkg::OP_TICK, pick_index(), $urandom);
				push_cmd(stb_pkg::OP_SCAN, pick_index(), $urandom);
				count += k + 1;
			end else if (r < 14) begin
				// run the pool full and one past it
				repeat (NT + 1) push_cmd(stb_pkg::OP_ALLOC, pick_index(), $urandom);
				count += NT + 1;
			end else if (r < 26) begin
				idx = stb_pkg::INDEX_W'($urandom_range(0, NT - 1));
				push_cmd(stb_pkg::OP_ALLOC, pick_index(), $urandom);
				push_cmd(stb_pkg::OP_SET_PER, idx, pick_period());
				if ($urandom_range(0, 1))
					push_cmd(stb_pkg::OP_RESTART, idx, $urandom);
				else
					push_cmd(stb_pkg::OP_MK_RDY, idx, $urandom);
				count += 3;
			end else begin
				push_cmd(pick_opcode(), pick_index(), pick_period());
				count++;
			end
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (cmd_queue.size() != 0 || start || timer_answers.size() != 0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty scan, error paths, zero and full-width periods, make ready
		idle_pct = 13;
		push_cmd(stb_pkg::OP_SCAN, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_RELEASE, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_RELEASE, 5'd31, 32'd0);
		push_cmd(stb_pkg::OP_SET_PER, 5'd16, 32'd5);
		push_cmd(stb_pkg::OP_RESTART, 5'd20, 32'd0);
		push_cmd(stb_pkg::OP_MK_RDY, 5'd31, 32'd0);
		push_cmd(OP_UNUSED, 5'd31, 32'hFFFF_FFFF);
		push_cmd(stb_pkg::OP_ALLOC, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_SET_PER, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_SET_PER, 5'd1, 32'hFFFF_FFFF);
		push_cmd(stb_pkg::OP_ALLOC, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_MK_RDY, 5'd1, 32'd0);
		push_cmd(stb_pkg::OP_SCAN, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_RESTART, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_TICK, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_SCAN, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_SET_PER, 5'd0, 32'd3);
		push_cmd(stb_pkg::OP_MK_RDY, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_SCAN, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_RELEASE, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_SCAN, 5'd0, 32'd0);
		push_cmd(stb_pkg::OP_SET_PER, 5'd15, 32'hAAAA_AAAA);
		push_cmd(stb_pkg::OP_SET_PER, 5'd2, 32'h5555_5555);
		drain();

		// three random phases, sender idling 13, 60 and then 0 percent of the time
		fill_random(545);
		drain();
		idle_pct = 60;
		fill_random(545);
		drain();
		idle_pct = 0;
		fill_random(545);
		drain();

		repeat (30) @(posedge clk);
		if (errors == 0 && timer_answers.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
sv/stb_pkg.sv
sv/soft_timer_bank.sv
verif/soft_timer_bank_tb.sv
